// File: design/rtcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcc_pkg: shared types, codes and helpers
// Beat payloads, counter groups and BCD digit helpers for the RTC calendar.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_PERIOD = 2'd1;
  localparam logic [1:0] REQ_DUTY   = 2'd2;
  localparam logic [1:0] REQ_LOAD   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_CLOCK_STOPPED   = 3'd0;
  localparam logic [2:0] CFG_CLOCK_PAUSED    = 3'd1;
  localparam logic [2:0] CFG_HOLD_COUNTING   = 3'd2;
  localparam logic [2:0] CFG_CALENDAR_ENABLE = 3'd3;
  localparam logic [2:0] CFG_MODE_24_HOUR    = 3'd4;
  localparam logic [2:0] CFG_IRQ_PERIOD_SEL  = 3'd5;
  localparam logic [2:0] CFG_IRQ_DUTY_MODE   = 3'd6;

  // month lengths
  localparam logic [4:0] DAYS_28 = 5'd28;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_31 = 5'd31;

  // month length by raw {high, low} month digits
  localparam logic [4:0] MONTH_LEN [32] = '{
    DAYS_30, DAYS_31, DAYS_28, DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31,
    DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30,
    DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30,
    DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30, DAYS_31, DAYS_30
  };

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] event_period;
    logic [6:0] load_seconds;
    logic [6:0] load_minutes;
    logic [6:0] load_hours;
    logic [5:0] load_days;
    logic [4:0] load_month;
    logic [7:0] load_year;
    logic [2:0] load_weekday;
  } rtcc_in_t;

  typedef struct packed {
    logic [6:0] seconds_now;
    logic [6:0] minutes_now;
    logic [6:0] hours_now;
    logic [5:0] days_now;
    logic [4:0] month_now;
    logic [7:0] year_now;
    logic [2:0] weekday_now;
    logic       irq_flag_now;
    logic       held_second_now;
    logic       resync_now;
  } rtcc_out_t;

  typedef struct packed {
    logic [2:0] index;
    logic [1:0] value;
  } rtcc_cfg_t;

  typedef struct packed {
    logic [3:0] sec_lo;
    logic [2:0] sec_hi;
    logic [3:0] min_lo;
    logic [2:0] min_hi;
    logic [3:0] hr_lo;
    logic [1:0] hr_hi;
    logic       pm;
  } rtcc_time_t;

  typedef struct packed {
    logic [3:0] day_lo;
    logic [1:0] day_hi;
    logic [3:0] mon_lo;
    logic       mon_hi;
    logic [3:0] yr_lo;
    logic [3:0] yr_hi;
    logic [2:0] dow;
  } rtcc_date_t;

  // digit counts up by one rather than carrying
  function automatic logic low_steps(input logic [3:0] d);
    return (d <= 4'd8) || (d == 4'd12);
  endfunction

  // carry value of a low digit: odd codes drop to 0, even ones to 1
  function automatic logic [3:0] odd_reset(input logic [3:0] d);
    return d[0] ? 4'd0 : 4'd1;
  endfunction

endpackage

`default_nettype wire

// File: design/rtcc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcc_stream_if: valid/ready channel
// Carries one payload beat per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface rtcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/rtcc_time_adv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcc_time_adv: one-second advance of the time digits
// Cascades seconds, minutes and hours in 12- or 24-hour mode and flags
// the day carry.
// ----------------------------------------------------------------------------
module rtcc_time_adv
  import rtcc_pkg::*;
(
  input  rtcc_time_t cur,
  input  logic       mode_24_hour,
  output rtcc_time_t nxt,
  output logic       day_carry
);

  logic min_go;
  logic hr_go;

  always_comb begin
    nxt       = cur;
    min_go    = 1'b0;
    hr_go     = 1'b0;
    day_carry = 1'b0;

    if (low_steps(cur.sec_lo)) begin
      nxt.sec_lo = cur.sec_lo + 4'd1;
    end else begin
      nxt.sec_lo = 4'd0;
      if (cur.sec_hi < 3'd5) begin
        nxt.sec_hi = cur.sec_hi + 3'd1;
      end else begin
        nxt.sec_hi = 3'd0;
        min_go     = 1'b1;
      end
    end

    if (min_go) begin
      if (low_steps(cur.min_lo)) begin
        nxt.min_lo = cur.min_lo + 4'd1;
      end else begin
        nxt.min_lo = 4'd0;
        if (cur.min_hi < 3'd5) begin
          nxt.min_hi = cur.min_hi + 3'd1;
        end else begin
          nxt.min_hi = 3'd0;
          hr_go      = 1'b1;
        end
      end
    end

    if (hr_go) begin
      if (mode_24_hour) begin
        if (cur.hr_hi < 2'd2) begin
          if (low_steps(cur.hr_lo)) begin
            nxt.hr_lo = cur.hr_lo + 4'd1;
          end else begin
            nxt.hr_lo = odd_reset(cur.hr_lo);
            nxt.hr_hi = cur.hr_hi + 2'd1;
          end
        end else if (cur.hr_lo != 4'd3 && !cur.hr_lo[2]) begin
          if (cur.hr_lo <= 4'd8 || cur.hr_lo >= 4'd12) begin
            nxt.hr_lo = cur.hr_lo + 4'd1;
          end else begin
            nxt.hr_lo = odd_reset(cur.hr_lo);
            nxt.hr_hi = cur.hr_hi + 2'd1;
          end
        end else begin
          nxt.hr_lo = odd_reset(cur.hr_lo);
          nxt.hr_hi = 2'd0;
          day_carry = 1'b1;
        end
      end else begin
        if (cur.hr_hi == 2'd0) begin
          if (low_steps(cur.hr_lo)) begin
            nxt.hr_lo = cur.hr_lo + 4'd1;
          end else begin
            nxt.hr_lo = odd_reset(cur.hr_lo);
            nxt.hr_hi = cur.hr_hi ^ 2'd1;
          end
        end else begin
          // odd low digit toggles AM/PM on the way through
          nxt.pm = cur.pm ^ cur.hr_lo[0];
          if (cur.hr_lo inside {4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd12}) begin
            nxt.hr_lo = cur.hr_lo + 4'd1;
          end else begin
            nxt.hr_lo = odd_reset(cur.hr_lo);
            nxt.hr_hi = cur.hr_hi ^ 2'd1;
          end
          day_carry = !nxt.pm && !nxt.hr_lo[0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/rtcc_date_adv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcc_date_adv: one-day advance of the calendar digits
// Steps the weekday and day, and cascades into month and year at month end.
// ----------------------------------------------------------------------------
module rtcc_date_adv
  import rtcc_pkg::*;
(
  input  rtcc_date_t cur,
  output rtcc_date_t nxt
);

  logic [4:0] mlen;
  logic       wrap;
  logic       leap;

  always_comb begin
    nxt = cur;

    nxt.dow = (cur.dow == 3'd6 || cur.dow == 3'd7) ? 3'd0 : cur.dow + 3'd1;

    leap = (!cur.yr_hi[0] && cur.yr_lo[1:0] == 2'd0) ||
           (cur.yr_hi[0] && cur.yr_lo[1:0] == 2'd2);
    mlen = MONTH_LEN[{cur.mon_hi, cur.mon_lo}];
    if (mlen == DAYS_28 && leap) begin
      mlen = DAYS_29;
    end

    case (mlen)
      DAYS_28: wrap = (cur.day_hi == 2'd3) ||
                      (cur.day_hi == 2'd2 && cur.day_lo >= 4'd8);
      DAYS_29: wrap = (cur.day_hi == 2'd3) ||
                      (cur.day_hi == 2'd2 && cur.day_lo > 4'd8 &&
                       cur.day_lo != 4'd12);
      DAYS_30: wrap = (cur.day_hi == 2'd3) ||
                      (cur.day_hi == 2'd2 && cur.day_lo inside {4'd10, 4'd14});
      DAYS_31: wrap = (cur.day_hi == 2'd3) && (cur.day_lo[1:0] != 2'd0);
      default: wrap = 1'b0;
    endcase

    if (wrap) begin
      nxt.day_lo = 4'd1;
      nxt.day_hi = 2'd0;
      if (!cur.mon_hi || !cur.mon_lo[1]) begin
        if (low_steps(cur.mon_lo)) begin
          nxt.mon_lo = cur.mon_lo + 4'd1;
        end else begin
          nxt.mon_lo = odd_reset(cur.mon_lo);
          nxt.mon_hi = !cur.mon_hi;
        end
      end else begin
        // year end
        nxt.mon_lo = odd_reset(cur.mon_lo);
        nxt.mon_hi = 1'b0;
        if (low_steps(cur.yr_lo)) begin
          nxt.yr_lo = cur.yr_lo + 4'd1;
        end else begin
          nxt.yr_lo = odd_reset(cur.yr_lo);
          nxt.yr_hi = low_steps(cur.yr_hi) ? cur.yr_hi + 4'd1 : odd_reset(cur.yr_hi);
        end
      end
    end else if (low_steps(cur.day_lo)) begin
      nxt.day_lo = cur.day_lo + 4'd1;
    end else begin
      nxt.day_lo = odd_reset(cur.day_lo);
      nxt.day_hi = cur.day_hi + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: design/bcd_rtc_calendar_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_counter: BCD real-time clock and calendar
// Digit counters, flags and control registers, with a registered result beat.
// ----------------------------------------------------------------------------
// Each accepted item beat (second tick, interrupt period event, duty event or
// time load) updates the BCD time, date and flag registers in the same clock
// and produces one result beat with the state after the update. The block
// takes one item per cycle while results are drained; the result appears
// in the output register in the cycle after acceptance; a new item is taken
// when it is empty or being drained. The cycle is set by the single-pass second,
// minute, hour, day, month and year cascade between the state registers.
// Configuration writes are taken at any time and should arrive while idle.
module bcd_rtc_calendar_counter
  import rtcc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  rtcc_stream_if.sink   item,
  rtcc_stream_if.source result,
  rtcc_stream_if.sink   cfg
);

  // control registers
  logic       clock_stopped;
  logic       clock_paused;
  logic       hold_counting;
  logic       calendar_enable;
  logic       mode_24_hour;
  logic [1:0] irq_period_select;
  logic       irq_duty_mode;

  // counter state
  rtcc_time_t time_q;
  rtcc_time_t time_next;
  rtcc_time_t time_adv;
  rtcc_date_t date_q;
  rtcc_date_t date_next;
  rtcc_date_t date_adv;
  logic       irq_pending;
  logic       irq_pending_next;
  logic       held_second;
  logic       held_second_next;
  logic       resync_flag;
  logic       resync_flag_next;
  logic       day_carry;

  // result register
  logic       out_valid;
  rtcc_out_t  out_data;

  rtcc_in_t   req;
  logic       fire;
  logic       running;

  assign req        = item.data;
  assign item.ready = !out_valid || result.ready;
  assign fire       = item.valid && item.ready;
  assign cfg.ready  = 1'b1;
  assign running    = !clock_stopped && !clock_paused;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  rtcc_time_adv u_time (
    .cur          (time_q),
    .mode_24_hour (mode_24_hour),
    .nxt          (time_adv),
    .day_carry    (day_carry)
  );

  rtcc_date_adv u_date (
    .cur (date_q),
    .nxt (date_adv)
  );

  always_comb begin
    time_next        = time_q;
    date_next        = date_q;
    irq_pending_next = irq_pending;
    held_second_next = held_second;
    resync_flag_next = resync_flag;
    case (req.req_type)
      REQ_TICK: begin
        if (running) begin
          if (hold_counting) begin
            held_second_next = 1'b1;
          end else begin
            resync_flag_next = 1'b1;
            time_next        = time_adv;
            if (day_carry && calendar_enable) begin
              date_next = date_adv;
            end
          end
        end
      end
      REQ_PERIOD: begin
        if (running && req.event_period == irq_period_select) begin
          irq_pending_next = 1'b1;
        end
      end
      REQ_DUTY: begin
        if (irq_duty_mode) begin
          irq_pending_next = 1'b0;
        end
      end
      REQ_LOAD: begin
        time_next.sec_lo = req.load_seconds[3:0];
        time_next.sec_hi = req.load_seconds[6:4];
        time_next.min_lo = req.load_minutes[3:0];
        time_next.min_hi = req.load_minutes[6:4];
        time_next.hr_lo  = req.load_hours[3:0];
        time_next.hr_hi  = req.load_hours[5:4];
        time_next.pm     = req.load_hours[6];
        date_next.day_lo = req.load_days[3:0];
        date_next.day_hi = req.load_days[5:4];
        date_next.mon_lo = req.load_month[3:0];
        date_next.mon_hi = req.load_month[4];
        date_next.yr_lo  = req.load_year[3:0];
        date_next.yr_hi  = req.load_year[7:4];
        date_next.dow    = req.load_weekday;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_stopped     <= 1'b0;
      clock_paused      <= 1'b0;
      hold_counting     <= 1'b0;
      calendar_enable   <= 1'b1;
      mode_24_hour      <= 1'b0;
      irq_period_select <= 2'd0;
      irq_duty_mode     <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_CLOCK_STOPPED:   clock_stopped     <= cfg.data.value[0];
        CFG_CLOCK_PAUSED:    clock_paused      <= cfg.data.value[0];
        CFG_HOLD_COUNTING:   hold_counting     <= cfg.data.value[0];
        CFG_CALENDAR_ENABLE: calendar_enable   <= cfg.data.value[0];
        CFG_MODE_24_HOUR:    mode_24_hour      <= cfg.data.value[0];
        CFG_IRQ_PERIOD_SEL:  irq_period_select <= cfg.data.value;
        CFG_IRQ_DUTY_MODE:   irq_duty_mode     <= cfg.data.value[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q      <= '0;
      date_q      <= '{day_lo: 4'd1, day_hi: 2'd0, mon_lo: 4'd1, mon_hi: 1'b0,
                       yr_lo: 4'd0, yr_hi: 4'd0, dow: 3'd0};
      irq_pending <= 1'b0;
      held_second <= 1'b0;
      resync_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        time_q      <= time_next;
        date_q      <= date_next;
        irq_pending <= irq_pending_next;
        held_second <= held_second_next;
        resync_flag <= resync_flag_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        // drop the beat once taken
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.seconds_now     <= {time_next.sec_hi, time_next.sec_lo};
      out_data.minutes_now     <= {time_next.min_hi, time_next.min_lo};
      out_data.hours_now       <= {time_next.pm, time_next.hr_hi, time_next.hr_lo};
      out_data.days_now        <= {date_next.day_hi, date_next.day_lo};
      out_data.month_now       <= {date_next.mon_hi, date_next.mon_lo};
      out_data.year_now        <= {date_next.yr_hi, date_next.yr_lo};
      out_data.weekday_now     <= date_next.dow;
      out_data.irq_flag_now    <= irq_pending_next;
      out_data.held_second_now <= held_second_next;
      out_data.resync_now      <= resync_flag_next;
    end
  end

  // sticky flags never fall outside reset
  a_resync_sticky: assert property (@(posedge clk) disable iff (rst)
    resync_flag |=> resync_flag)
    else $error("resync flag cleared without reset");

  a_held_sticky: assert property (@(posedge clk) disable iff (rst)
    held_second |=> held_second)
    else $error("held-second flag cleared without reset");

  // counters move only on an accepted beat
  a_time_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(time_q) && $stable(date_q)))
    else $error("counters changed without an accepted beat");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (fire && req.req_type == REQ_LOAD) |=>
      (out_valid && out_data.seconds_now == $past(req.load_seconds) &&
       out_data.year_now == $past(req.load_year)))
    else $error("load beat not reflected in result");

endmodule

`default_nettype wire

// File: dv/bcd_rtc_calendar_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_counter_tb: self-checking bench for the BCD RTC calendar
// Feeds ticks, interrupt events and time loads under a range of control
// settings and checks every result beat against an in-bench calendar model.
// ----------------------------------------------------------------------------
module bcd_rtc_calendar_counter_tb;
  import rtcc_pkg::*;

  localparam int          PHASES        = 9;
  localparam int          TAIL_STEPS    = 120;
  localparam int          SETTLE_CYCLES = 3;
  localparam int          DRAIN_CYCLES  = 8;
  localparam longint      TIMEOUT_NS    = 2_000_000;
  localparam logic [2:0]  CFG_UNMAPPED  = 3'd7;

  typedef struct {
    bit         is_cfg;
    rtcc_in_t   it;
    rtcc_cfg_t  wr;
  } step_t;

  logic clk;
  logic rst;

  rtcc_stream_if #(.payload_t(rtcc_in_t))  item_bus ();
  rtcc_stream_if #(.payload_t(rtcc_out_t)) result_bus ();
  rtcc_stream_if #(.payload_t(rtcc_cfg_t)) cfg_bus ();

  bcd_rtc_calendar_counter u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  step_t       pending_steps[$];
  rtcc_out_t   expected_readings[$];
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned cfg_writes;
  int unsigned tally[4];
  int          gap_left;
  int          stall_left;
  int          idle_cycles;
  bit          tail_phase;

  // model state and control registers
  rtcc_time_t now_time;
  rtcc_date_t now_date;
  logic       irq_flag, held_flag, resync_seen;
  logic       stopped_q, paused_q, hold_q, cal_en_q, h24_q, duty_q;
  logic [1:0] period_sel_q;

  // ---------------------------------------------------------------- model

  function automatic void reset_calendar();
    now_time     = '0;
    now_date     = '0;
    now_date.day_lo = 4'd1;
    now_date.mon_lo = 4'd1;
    irq_flag     = 1'b0;
    held_flag    = 1'b0;
    resync_seen  = 1'b0;
    stopped_q    = 1'b0;
    paused_q     = 1'b0;
    hold_q       = 1'b0;
    cal_en_q     = 1'b1;
    h24_q        = 1'b0;
    period_sel_q = 2'd0;
    duty_q       = 1'b0;
  endfunction

  function automatic void write_register(input rtcc_cfg_t w);
    case (w.index)
      CFG_CLOCK_STOPPED:   stopped_q    = w.value[0];
      CFG_CLOCK_PAUSED:    paused_q     = w.value[0];
      CFG_HOLD_COUNTING:   hold_q       = w.value[0];
      CFG_CALENDAR_ENABLE: cal_en_q     = w.value[0];
      CFG_MODE_24_HOUR:    h24_q        = w.value[0];
      CFG_IRQ_PERIOD_SEL:  period_sel_q = w.value;
      CFG_IRQ_DUTY_MODE:   duty_q       = w.value[0];
      default: ;
    endcase
  endfunction

  // digit increments in place instead of carrying
  function automatic bit counts_up(input logic [3:0] d);
    return (d <= 4'd8) || (d == 4'd12);
  endfunction

  function automatic logic [3:0] carry_digit(input logic [3:0] d);
    return d[0] ? 4'd0 : 4'd1;
  endfunction

  // raw {high, low} month code to days
  function automatic logic [4:0] month_length(input logic [4:0] m);
    if (m == 5'd2) return 5'd28;
    if (m < 5'd8) return m[0] ? 5'd31 : 5'd30;
    return m[0] ? 5'd30 : 5'd31;
  endfunction

  function automatic void bump_year();
    if (counts_up(now_date.yr_lo)) begin
      now_date.yr_lo = now_date.yr_lo + 4'd1;
    end else begin
      now_date.yr_lo = carry_digit(now_date.yr_lo);
      if (counts_up(now_date.yr_hi)) now_date.yr_hi = now_date.yr_hi + 4'd1;
      else now_date.yr_hi = carry_digit(now_date.yr_hi);
    end
  endfunction

  function automatic void bump_month();
    if (!now_date.mon_hi || !now_date.mon_lo[1]) begin
      if (counts_up(now_date.mon_lo)) begin
        now_date.mon_lo = now_date.mon_lo + 4'd1;
      end else begin
        now_date.mon_lo = carry_digit(now_date.mon_lo);
        now_date.mon_hi = ~now_date.mon_hi;
      end
    end else begin
      now_date.mon_lo = carry_digit(now_date.mon_lo);
      now_date.mon_hi = 1'b0;
      bump_year();
    end
  endfunction

  function automatic void bump_day();
    logic [4:0] len;
    logic [3:0] lo;
    logic [1:0] hi;
    bit         wrap;
    if (!cal_en_q) return;
    now_date.dow = now_date.dow + 3'd1 + (now_date.dow == 3'd6);
    len = month_length({now_date.mon_hi, now_date.mon_lo});
    // leap rule keyed on the parity of the year's high digit
    if (len == 5'd28) begin
      if (!now_date.yr_hi[0] && now_date.yr_lo[1:0] == 2'd0) len++;
      if (now_date.yr_hi[0] && now_date.yr_lo[1:0] == 2'd2) len++;
    end
    lo   = now_date.day_lo;
    hi   = now_date.day_hi;
    wrap = 1'b0;
    if (len == 5'd28 && (hi == 2'd3 || (hi == 2'd2 && lo >= 4'd8))) wrap = 1'b1;
    if (len == 5'd29 && (hi == 2'd3 ||
        (hi == 2'd2 && lo > 4'd8 && lo != 4'd12))) wrap = 1'b1;
    if (len == 5'd30 && (hi == 2'd3 ||
        (hi == 2'd2 && (lo == 4'd10 || lo == 4'd14)))) wrap = 1'b1;
    if (len == 5'd31 && hi == 2'd3 && lo[1:0] != 2'd0) wrap = 1'b1;
    if (wrap) begin
      now_date.day_lo = 4'd1;
      now_date.day_hi = 2'd0;
      bump_month();
    end else if (counts_up(lo)) begin
      now_date.day_lo = lo + 4'd1;
    end else begin
      now_date.day_lo = carry_digit(lo);
      now_date.day_hi = hi + 2'd1;
    end
  endfunction

  function automatic void bump_hour();
    logic [3:0] lo;
    lo = now_time.hr_lo;
    if (h24_q) begin
      if (now_time.hr_hi < 2'd2) begin
        if (counts_up(lo)) begin
          now_time.hr_lo = lo + 4'd1;
        end else begin
          now_time.hr_lo = carry_digit(lo);
          now_time.hr_hi = now_time.hr_hi + 2'd1;
        end
      end else if (lo != 4'd3 && !lo[2]) begin
        if (lo <= 4'd8 || lo >= 4'd12) begin
          now_time.hr_lo = lo + 4'd1;
        end else begin
          now_time.hr_lo = carry_digit(lo);
          now_time.hr_hi = now_time.hr_hi + 2'd1;
        end
      end else begin
        now_time.hr_lo = carry_digit(lo);
        now_time.hr_hi = 2'd0;
        bump_day();
      end
    end else begin
      if (now_time.hr_hi == 2'd0) begin
        if (counts_up(lo)) begin
          now_time.hr_lo = lo + 4'd1;
        end else begin
          now_time.hr_lo = carry_digit(lo);
          now_time.hr_hi[0] = ~now_time.hr_hi[0];
        end
      end else begin
        if (lo[0]) now_time.pm = ~now_time.pm;
        if (lo < 4'd2 || lo == 4'd4 || lo == 4'd5 || lo == 4'd8 || lo == 4'd12) begin
          now_time.hr_lo = lo + 4'd1;
        end else begin
          now_time.hr_lo = carry_digit(lo);
          now_time.hr_hi[0] = ~now_time.hr_hi[0];
        end
        // midnight in 12-hour mode: AM with an even low digit
        if (!now_time.pm && !now_time.hr_lo[0]) bump_day();
      end
    end
  endfunction

  function automatic void bump_minute();
    if (counts_up(now_time.min_lo)) begin
      now_time.min_lo = now_time.min_lo + 4'd1;
    end else begin
      now_time.min_lo = 4'd0;
      if (now_time.min_hi < 3'd5) begin
        now_time.min_hi = now_time.min_hi + 3'd1;
      end else begin
        now_time.min_hi = 3'd0;
        bump_hour();
      end
    end
  endfunction

  function automatic void bump_second();
    if (counts_up(now_time.sec_lo)) begin
      now_time.sec_lo = now_time.sec_lo + 4'd1;
    end else begin
      now_time.sec_lo = 4'd0;
      if (now_time.sec_hi < 3'd5) begin
        now_time.sec_hi = now_time.sec_hi + 3'd1;
      end else begin
        now_time.sec_hi = 3'd0;
        bump_minute();
      end
    end
  endfunction

  function automatic rtcc_out_t next_reading(input rtcc_in_t it);
    rtcc_out_t r;
    case (it.req_type)
      REQ_TICK: begin
        if (!stopped_q && !paused_q) begin
          if (hold_q) begin
            held_flag = 1'b1;
          end else begin
            resync_seen = 1'b1;
            bump_second();
          end
        end
      end
      REQ_PERIOD: begin
        if (!stopped_q && !paused_q && it.event_period == period_sel_q) irq_flag = 1'b1;
      end
      REQ_DUTY: begin
        if (duty_q) irq_flag = 1'b0;
      end
      default: begin
        now_time.sec_lo = it.load_seconds[3:0];
        now_time.sec_hi = it.load_seconds[6:4];
        now_time.min_lo = it.load_minutes[3:0];
        now_time.min_hi = it.load_minutes[6:4];
        now_time.hr_lo  = it.load_hours[3:0];
        now_time.hr_hi  = it.load_hours[5:4];
        now_time.pm     = it.load_hours[6];
        now_date.day_lo = it.load_days[3:0];
        now_date.day_hi = it.load_days[5:4];
        now_date.mon_lo = it.load_month[3:0];
        now_date.mon_hi = it.load_month[4];
        now_date.yr_lo  = it.load_year[3:0];
        now_date.yr_hi  = it.load_year[7:4];
        now_date.dow    = it.load_weekday;
      end
    endcase
    r.seconds_now     = {now_time.sec_hi, now_time.sec_lo};
    r.minutes_now     = {now_time.min_hi, now_time.min_lo};
    r.hours_now       = {now_time.pm, now_time.hr_hi, now_time.hr_lo};
    r.days_now        = {now_date.day_hi, now_date.day_lo};
    r.month_now       = {now_date.mon_hi, now_date.mon_lo};
    r.year_now        = {now_date.yr_hi, now_date.yr_lo};
    r.weekday_now     = now_date.dow;
    r.irq_flag_now    = irq_flag;
    r.held_second_now = held_flag;
    r.resync_now      = resync_seen;
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic void push_item(input rtcc_in_t it);
    step_t s;
    s.is_cfg = 1'b0;
    s.it     = it;
    s.wr     = '0;
    pending_steps.push_back(s);
  endfunction

  function automatic void push_cfg(input logic [2:0] idx, input logic [1:0] v);
    step_t s;
    s.is_cfg   = 1'b1;
    s.it       = '0;
    s.wr.index = idx;
    s.wr.value = v;
    pending_steps.push_back(s);
  endfunction

  function automatic void push_event(input logic [1:0] req, input logic [1:0] period);
    rtcc_in_t it;
    it              = '0;
    it.req_type     = req;
    it.event_period = period;
    push_item(it);
  endfunction

  function automatic void push_load(input logic [6:0] s, input logic [6:0] m,
                                    input logic [6:0] h, input logic [5:0] d,
                                    input logic [4:0] mo, input logic [7:0] y,
                                    input logic [2:0] w);
    rtcc_in_t it;
    it              = '0;
    it.req_type     = REQ_LOAD;
    it.load_seconds = s;
    it.load_minutes = m;
    it.load_hours   = h;
    it.load_days    = d;
    it.load_month   = mo;
    it.load_year    = y;
    it.load_weekday = w;
    push_item(it);
  endfunction

  function automatic rtcc_in_t noise_item();
    rtcc_in_t it;
    it.req_type     = $urandom_range(0, 3);
    it.event_period = $urandom_range(0, 3);
    it.load_seconds = $urandom_range(0, 127);
    it.load_minutes = $urandom_range(0, 127);
    it.load_hours   = $urandom_range(0, 127);
    it.load_days    = $urandom_range(0, 63);
    it.load_month   = $urandom_range(0, 31);
    it.load_year    = $urandom_range(0, 255);
    it.load_weekday = $urandom_range(0, 7);
    return it;
  endfunction

  function automatic rtcc_in_t tick_item();
    rtcc_in_t it;
    it          = noise_item();
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // time loaded a tick or two short of a rollover, with some raw noise left in
  function automatic rtcc_in_t edge_load();
    rtcc_in_t   it;
    logic [7:0] m;
    it          = noise_item();
    it.req_type = REQ_LOAD;
    if ($urandom_range(0, 4) != 0) it.load_seconds = ($urandom_range(0, 3) == 0) ? 7'h58 : 7'h59;
    if ($urandom_range(0, 5) != 0) it.load_minutes = 7'h59;
    case ($urandom_range(0, 7))
      0: it.load_hours[5:0] = 6'h11;
      1: it.load_hours[5:0] = 6'h12;
      2: it.load_hours[5:0] = 6'h09;
      3: it.load_hours[5:0] = 6'h23;
      4: it.load_hours[5:0] = 6'h19;
      5: it.load_hours[5:0] = 6'h01;
      6: it.load_hours[5:0] = 6'h10;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: it.load_days = 6'h28;
      1: it.load_days = 6'h29;
      2: it.load_days = 6'h30;
      3: it.load_days = 6'h31;
      4: it.load_days = 6'h19;
      default: ;
    endcase
    if ($urandom_range(0, 4) != 0) begin
      m = $urandom_range(1, 12);
      it.load_month = (m < 8'd10) ? m[4:0] : {1'b1, 4'(m - 8'd10)};
    end
    if ($urandom_range(0, 3) != 0) begin
      it.load_year[7:4] = $urandom_range(0, 9);
      it.load_year[3:0] = $urandom_range(0, 9);
    end
    return it;
  endfunction

  // load near a rollover, then a few ticks with the odd interrupt event mixed in
  function automatic int push_rollover_run();
    int       n;
    int       ticks;
    rtcc_in_t it;
    push_item(edge_load());
    n     = 1;
    ticks = $urandom_range(1, 4);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        it          = noise_item();
        it.req_type = ($urandom_range(0, 1) == 0) ? REQ_PERIOD : REQ_DUTY;
        push_item(it);
        n++;
      end
      push_item(tick_item());
      n++;
    end
    return n;
  endfunction

  function automatic rtcc_in_t noise_step();
    rtcc_in_t it;
    it = noise_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.req_type = REQ_TICK;
      5, 6:          it.req_type = REQ_PERIOD;
      7:             it.req_type = REQ_DUTY;
      default:       it.req_type = REQ_LOAD;
    endcase
    return it;
  endfunction

  // one-bit registers sometimes get a value with the upper bit set too
  function automatic logic [1:0] flag_value(input bit b);
    return {($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0, b};
  endfunction

  function automatic void push_phase_config(input int phase);
    case (phase)
      0: begin
        push_cfg(CFG_CLOCK_STOPPED, 2'd0);
        push_cfg(CFG_CLOCK_PAUSED, 2'd0);
        push_cfg(CFG_HOLD_COUNTING, 2'd0);
        push_cfg(CFG_CALENDAR_ENABLE, 2'd0);
        push_cfg(CFG_MODE_24_HOUR, 2'd0);
        push_cfg(CFG_IRQ_PERIOD_SEL, 2'd0);
        push_cfg(CFG_IRQ_DUTY_MODE, 2'd0);
      end
      1: begin
        push_cfg(CFG_CLOCK_STOPPED, 2'd0);
        push_cfg(CFG_CLOCK_PAUSED, 2'd0);
        push_cfg(CFG_HOLD_COUNTING, 2'd0);
        push_cfg(CFG_CALENDAR_ENABLE, 2'd1);
        push_cfg(CFG_MODE_24_HOUR, 2'd1);
        push_cfg(CFG_IRQ_PERIOD_SEL, 2'd3);
        push_cfg(CFG_IRQ_DUTY_MODE, 2'd1);
      end
      2: begin
        push_cfg(CFG_CLOCK_STOPPED, 2'd3);
        push_cfg(CFG_CLOCK_PAUSED, 2'd1);
        push_cfg(CFG_HOLD_COUNTING, 2'd1);
        push_cfg(CFG_CALENDAR_ENABLE, 2'd1);
        push_cfg(CFG_MODE_24_HOUR, 2'd1);
        push_cfg(CFG_IRQ_PERIOD_SEL, 2'd3);
        push_cfg(CFG_IRQ_DUTY_MODE, 2'd1);
      end
      default: begin
        // keep counting alive most of the time
        push_cfg(CFG_CLOCK_STOPPED, flag_value($urandom_range(0, 5) == 0));
        push_cfg(CFG_CLOCK_PAUSED, flag_value($urandom_range(0, 5) == 0));
        push_cfg(CFG_HOLD_COUNTING, flag_value($urandom_range(0, 4) == 0));
        push_cfg(CFG_CALENDAR_ENABLE, flag_value($urandom_range(0, 3) != 0));
        push_cfg(CFG_MODE_24_HOUR, flag_value($urandom_range(0, 1) == 1));
        push_cfg(CFG_IRQ_PERIOD_SEL, $urandom_range(0, 3));
        push_cfg(CFG_IRQ_DUTY_MODE, flag_value($urandom_range(0, 1) == 1));
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // ------------------------------------------------------------- clocking

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $error("timeout with %0d steps pending and %0d results outstanding",
           pending_steps.size(), expected_readings.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive
    logic  item_v;
    logic  cfg_v;
    step_t nxt;
    item_v = item_bus.valid;
    cfg_v  = cfg_bus.valid;
    if (rst) begin
      item_v      = 1'b0;
      cfg_v       = 1'b0;
      gap_left    = 0;
      idle_cycles = 0;
      reset_calendar();
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        expected_readings.push_back(next_reading(item_bus.data));
        tally[item_bus.data.req_type]++;
        item_v = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        write_register(cfg_bus.data);
        cfg_writes++;
        cfg_v = 1'b0;
      end
      if (item_v || cfg_v || expected_readings.size() != 0) idle_cycles = 0;
      else idle_cycles++;
      if (!item_v && !cfg_v && pending_steps.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_steps[0].is_cfg) begin
          // write registers only once the block has drained
          if (idle_cycles >= SETTLE_CYCLES) begin
            nxt = pending_steps.pop_front();
            cfg_bus.data <= nxt.wr;
            cfg_v = 1'b1;
          end
        end else begin
          nxt = pending_steps.pop_front();
          item_bus.data <= nxt.it;
          item_v = 1'b1;
          if (!tail_phase && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 6);
        end
      end
    end
    item_bus.valid <= item_v;
    cfg_bus.valid  <= cfg_v;
    tail_phase     <= (pending_steps.size() < TAIL_STEPS);
  end

  // --------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch
    rtcc_out_t want;
    rtcc_out_t got;
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = result_bus.data;
        if (expected_readings.size() == 0) begin
          $error("result beat 0x%0h arrived with nothing expected", got);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("seconds_now", want.seconds_now, got.seconds_now);
          check_field("minutes_now", want.minutes_now, got.minutes_now);
          check_field("hours_now", want.hours_now, got.hours_now);
          check_field("days_now", want.days_now, got.days_now);
          check_field("month_now", want.month_now, got.month_now);
          check_field("year_now", want.year_now, got.year_now);
          check_field("weekday_now", want.weekday_now, got.weekday_now);
          check_field("irq_flag_now", want.irq_flag_now, got.irq_flag_now);
          check_field("held_second_now", want.held_second_now, got.held_second_now);
          check_field("resync_now", want.resync_now, got.resync_now);
          checked_count++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    int n;
    int quota;
    rst              = 1'b1;
    item_bus.valid   = 1'b0;
    item_bus.data    = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = '0;
    result_bus.ready = 1'b0;
    tail_phase       = 1'b0;
    mismatch_count   = 0;
    checked_count    = 0;
    cfg_writes       = 0;
    foreach (tally[i]) tally[i] = 0;
    reset_calendar();

    // 12-hour rollover into March of a common year, end of century, leap days
    push_load(7'h59, 7'h59, {1'b1, 6'h11}, 6'h28, 5'h02, 8'h23, 3'd6);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h59, 7'h59, {1'b1, 6'h11}, 6'h31, 5'h12, 8'h99, 3'd5);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h59, 7'h59, {1'b1, 6'h11}, 6'h28, 5'h02, 8'h24, 3'd1);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h59, 7'h59, {1'b1, 6'h11}, 6'h29, 5'h02, 8'h24, 3'd2);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h59, 7'h59, {1'b1, 6'h11}, 6'h29, 5'h02, 8'h12, 3'd7);
    push_event(REQ_TICK, 2'd0);
    // every digit at its top raw value, then a tick and interrupt events
    push_load(7'h7F, 7'h7F, 7'h7F, 6'h3F, 5'h1F, 8'hFF, 3'd7);
    push_event(REQ_TICK, 2'd0);
    push_event(REQ_PERIOD, 2'd0);
    push_event(REQ_PERIOD, 2'd3);
    push_event(REQ_DUTY, 2'd0);
    push_cfg(CFG_IRQ_DUTY_MODE, 2'd1);
    push_cfg(CFG_IRQ_PERIOD_SEL, 2'd3);
    push_event(REQ_DUTY, 2'd0);
    push_event(REQ_PERIOD, 2'd3);
    // 24-hour midnight into May, then an invalid hour
    push_cfg(CFG_MODE_24_HOUR, 2'd1);
    push_load(7'h59, 7'h59, 7'h23, 6'h30, 5'h04, 8'h25, 3'd3);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h59, 7'h59, 7'h3F, 6'h15, 5'h08, 8'h31, 3'd4);
    push_event(REQ_TICK, 2'd0);
    // calendar off: the hour wraps, the date stays
    push_cfg(CFG_CALENDAR_ENABLE, 2'd0);
    push_load(7'h59, 7'h59, 7'h23, 6'h31, 5'h01, 8'h40, 3'd0);
    push_event(REQ_TICK, 2'd0);
    push_cfg(CFG_HOLD_COUNTING, 2'd1);
    push_event(REQ_TICK, 2'd0);
    push_cfg(CFG_HOLD_COUNTING, 2'd0);
    push_cfg(CFG_CLOCK_STOPPED, 2'd1);
    push_event(REQ_TICK, 2'd0);
    push_load(7'h00, 7'h00, 7'h00, 6'h00, 5'h00, 8'h00, 3'd0);
    push_cfg(CFG_CLOCK_STOPPED, 2'd0);
    push_cfg(CFG_CLOCK_PAUSED, 2'd1);
    push_event(REQ_TICK, 2'd0);
    push_event(REQ_PERIOD, 2'd3);
    push_cfg(CFG_CLOCK_PAUSED, 2'd0);
    push_cfg(CFG_UNMAPPED, 2'd3);

    for (int ph = 0; ph < PHASES; ph++) begin
      push_phase_config(ph);
      quota = (ph == 2) ? 40 : 100;
      n = 0;
      while (n < quota) begin
        if ($urandom_range(0, 9) < 6) begin
          n += push_rollover_run();
        end else begin
          push_item(noise_step());
          n++;
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_steps.size() != 0 || item_bus.valid || cfg_bus.valid ||
           expected_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d period events, %0d duty events, %0d time loads",
             tally[REQ_TICK], tally[REQ_PERIOD], tally[REQ_DUTY], tally[REQ_LOAD]);
    $display("%0d register writes over %0d settings; %0d result beats checked",
             cfg_writes, PHASES + 1, checked_count);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
